@@ src/double_ended_arena_allocator_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the double-ended arena allocator
// Implication checks on the core clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_ARENA_ALLOCATOR_CORE_DEFINES_SVH
`define DOUBLE_ENDED_ARENA_ALLOCATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define DEAA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deaa assertion failed");
// next-cycle implication
`define DEAA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deaa assertion failed");
`else
`define DEAA_ASSERT_NOW(label, clk, rst, ante, cons)
`define DEAA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/deaa_pkg.sv @@
// ---------------------------------------------------------------------------
// deaa_pkg
// Field widths, operation and status codes, engine states.
// ---------------------------------------------------------------------------
package deaa_pkg;

   localparam int FIELD_W  = 21;
   localparam int OPCODE_W = 3;
   localparam int STATUS_W = 3;

   // back blocks are aligned to 8 bytes
   localparam int ALIGN_MASK  = 7;
   localparam int ALIGN_SHIFT = 3;

   typedef enum logic [OPCODE_W-1:0] {
      OP_MARK        = 3'd0,
      OP_FRONT_ALLOC = 3'd1,
      OP_FRONT_RESET = 3'd2,
      OP_BACK_ALLOC  = 3'd3,
      OP_BACK_FREE   = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_NO_SPACE   = 3'd1,
      STAT_TABLE_FULL = 3'd2,
      STAT_BAD_RESET  = 3'd3,
      STAT_NOT_FOUND  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

@@ src/deaa_req_if.sv @@
// ---------------------------------------------------------------------------
// deaa_req_if
// Request channel: valid/ready handshake with opcode, size and address.
// ---------------------------------------------------------------------------
interface deaa_req_if;
   logic                          valid;
   logic                          ready;
   logic [deaa_pkg::OPCODE_W-1:0] opcode;
   logic [deaa_pkg::FIELD_W-1:0]  size;
   logic [deaa_pkg::FIELD_W-1:0]  address;

   modport source (output valid, output opcode, output size, output address, input ready);
   modport sink   (input valid, input opcode, input size, input address, output ready);
endinterface

@@ src/deaa_rsp_if.sv @@
// ---------------------------------------------------------------------------
// deaa_rsp_if
// Response channel: valid/ready handshake with address, status and usage.
// ---------------------------------------------------------------------------
interface deaa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [deaa_pkg::FIELD_W-1:0]  result_address;
   logic [deaa_pkg::STATUS_W-1:0] status;
   logic [deaa_pkg::FIELD_W-1:0]  used_bytes;
   logic [deaa_pkg::FIELD_W-1:0]  peak_bytes;

   modport source (output valid, output result_address, output status,
                   output used_bytes, output peak_bytes, input ready);
   modport sink   (input valid, input result_address, input status,
                   input used_bytes, input peak_bytes, output ready);
endinterface

@@ src/double_ended_arena_allocator_core.sv @@
// ---------------------------------------------------------------------------
// double_ended_arena_allocator_core
// Arena managed from both ends; back block depths kept in an on-chip table.
// ---------------------------------------------------------------------------
//
//  channel    dir  handshake          payload
//  req_chan   in   valid/ready        opcode, size, address
//  rsp_chan   out  valid/ready        result_address, status, used_bytes,
//                                     peak_bytes
//
//  Mark, front alloc, front reset and back alloc go from the input buffer
//  through the DONE state to the response register; back free also runs
//  the table scan, which reads one entry per cycle from the RAM.
//  Reset is synchronous; the depth table needs no clearing pass, since only
//  entries below back_count are ever read.
//  A one-item input buffer takes the next request while a response waits;
//  the engine holds its result while rsp_chan is stalled.
// ---------------------------------------------------------------------------
`include "double_ended_arena_allocator_core_defines.svh"

module double_ended_arena_allocator_core #(
   parameter int ARENA_BYTES     = 1048576,
   parameter int MAX_BACK_BLOCKS = 128
) (
   input  logic        clock,
   input  logic        reset,
   deaa_req_if.sink    req_chan,
   deaa_rsp_if.source  rsp_chan
);

   // level registers hold 0..ARENA_BYTES
   localparam int LEVEL_W = $clog2(ARENA_BYTES + 1);
   // sums of levels and 21-bit fields never overflow this width
   localparam int WIDE_W  = ((LEVEL_W > deaa_pkg::FIELD_W) ? LEVEL_W : deaa_pkg::FIELD_W) + 2;
   // table fill count holds 0..MAX_BACK_BLOCKS, table index one less
   localparam int CNT_W   = $clog2(MAX_BACK_BLOCKS + 1);
   localparam int ADDR_W  = (MAX_BACK_BLOCKS > 1) ? $clog2(MAX_BACK_BLOCKS) : 1;

   localparam logic [WIDE_W-1:0] ARENA_WIDE = WIDE_W'(ARENA_BYTES);
   localparam logic [WIDE_W-1:0] ALIGN_WIDE = WIDE_W'(deaa_pkg::ALIGN_MASK);
   localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_BACK_BLOCKS);

   // ---- input buffer -------------------------------------------------------
   logic                          buf_valid_ff, buf_valid_in;
   logic [deaa_pkg::OPCODE_W-1:0] buf_opcode_ff;
   logic [deaa_pkg::FIELD_W-1:0]  buf_size_ff;
   logic [deaa_pkg::FIELD_W-1:0]  buf_address_ff;
   logic                          req_take;

   // ---- allocator state ----------------------------------------------------
   deaa_pkg::state_type  state_ff, state_in;
   logic [LEVEL_W-1:0]   front_ff, front_in;
   logic [LEVEL_W-1:0]   back_ff, back_in;
   logic [LEVEL_W-1:0]   peak_ff, peak_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   // ---- per-item result ----------------------------------------------------
   logic [deaa_pkg::FIELD_W-1:0] res_addr_ff, res_addr_in;
   deaa_pkg::status_type         status_ff, status_in;

   // ---- free scan ----------------------------------------------------------
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               scan_pend_ff, scan_pend_in;
   logic [CNT_W-1:0]   kept_ff, kept_in;
   logic [LEVEL_W-1:0] largest_ff, largest_in;
   logic               found_ff, found_in;
   logic [LEVEL_W-1:0] depth_ff, depth_in;
   logic               match_en_ff, match_en_in;

   // ---- response register --------------------------------------------------
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [deaa_pkg::FIELD_W-1:0]  rsp_addr_ff, rsp_addr_in;
   logic [deaa_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [deaa_pkg::FIELD_W-1:0]  rsp_used_ff, rsp_used_in;
   logic [deaa_pkg::FIELD_W-1:0]  rsp_peak_ff, rsp_peak_in;
   logic                          out_free;

   // ---- table RAM ----------------------------------------------------------
   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [LEVEL_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [LEVEL_W-1:0] ram_rd_data;

   // ---- datapath temporaries -----------------------------------------------
   logic [WIDE_W-1:0] front_w, back_w, size_w, addr_w;
   logic [WIDE_W-1:0] rounded_w, front_need_w, back_need_w, back_new_w;
   logic [WIDE_W-1:0] reset_lim_w, depth_w, used_w, res_w;

   function automatic logic [deaa_pkg::FIELD_W-1:0] res_trunc(input logic [LEVEL_W-1:0] lvl);
      logic [WIDE_W-1:0] wide;
      wide      = WIDE_W'(lvl);
      res_trunc = wide[deaa_pkg::FIELD_W-1:0];
   endfunction

   deaa_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (MAX_BACK_BLOCKS)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready = !buf_valid_ff;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.used_bytes     = rsp_used_ff;
   assign rsp_chan.peak_bytes     = rsp_peak_ff;

   // shared datapath terms
   always_comb begin
      front_w      = WIDE_W'(front_ff);
      back_w       = WIDE_W'(back_ff);
      size_w       = WIDE_W'(buf_size_ff);
      addr_w       = WIDE_W'(buf_address_ff);
      // round up to the 8-byte grain
      rounded_w    = ((size_w + ALIGN_WIDE) >> deaa_pkg::ALIGN_SHIFT) << deaa_pkg::ALIGN_SHIFT;
      front_need_w = front_w + back_w + size_w;
      back_need_w  = front_w + back_w + rounded_w;
      back_new_w   = back_w + rounded_w;
      reset_lim_w  = ARENA_WIDE - back_w;
      depth_w      = ARENA_WIDE - addr_w;
      used_w       = front_w + back_w;
      res_w        = ARENA_WIDE - back_new_w;
   end

   // engine: next state and outputs
   always_comb begin
      state_in      = state_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      peak_in       = peak_ff;
      count_in      = count_ff;
      res_addr_in   = res_addr_ff;
      status_in     = status_ff;
      scan_idx_in   = scan_idx_ff;
      scan_pend_in  = 1'b0;
      kept_in       = kept_ff;
      largest_in    = largest_ff;
      found_in      = found_ff;
      depth_in      = depth_ff;
      match_en_in   = match_en_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_peak_in   = rsp_peak_ff;
      req_take      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = count_ff[ADDR_W-1:0];
      ram_wr_data   = back_new_w[LEVEL_W-1:0];
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_idx_ff[ADDR_W-1:0];

      case (state_ff)
         deaa_pkg::ST_IDLE: begin
            if (buf_valid_ff) begin
               req_take  = 1'b1;
               state_in  = deaa_pkg::ST_DONE;
               status_in = deaa_pkg::STAT_OK;
               case (deaa_pkg::opcode_type'(buf_opcode_ff))
                  deaa_pkg::OP_FRONT_ALLOC: begin
                     if (front_need_w > ARENA_WIDE) begin
                        status_in   = deaa_pkg::STAT_NO_SPACE;
                        res_addr_in = '0;
                     end else begin
                        res_addr_in = front_w[deaa_pkg::FIELD_W-1:0];
                        front_in    = front_ff + LEVEL_W'(buf_size_ff);
                     end
                  end
                  deaa_pkg::OP_FRONT_RESET: begin
                     if (addr_w > reset_lim_w) begin
                        status_in   = deaa_pkg::STAT_BAD_RESET;
                        res_addr_in = front_w[deaa_pkg::FIELD_W-1:0];
                     end else begin
                        front_in    = addr_w[LEVEL_W-1:0];
                        res_addr_in = buf_address_ff;
                     end
                  end
                  deaa_pkg::OP_BACK_ALLOC: begin
                     res_addr_in = '0;
                     // table full is checked ahead of space
                     if (count_ff >= MAX_CNT) begin
                        status_in = deaa_pkg::STAT_TABLE_FULL;
                     end else if (back_need_w > ARENA_WIDE) begin
                        status_in = deaa_pkg::STAT_NO_SPACE;
                     end else begin
                        back_in     = back_new_w[LEVEL_W-1:0];
                        count_in    = count_ff + CNT_W'(1);
                        ram_wr_en   = 1'b1;
                        res_addr_in = res_w[deaa_pkg::FIELD_W-1:0];
                     end
                  end
                  deaa_pkg::OP_BACK_FREE: begin
                     res_addr_in = buf_address_ff;
                     // an address past the arena end matches nothing
                     match_en_in = addr_w <= ARENA_WIDE;
                     depth_in    = depth_w[LEVEL_W-1:0];
                     scan_idx_in = '0;
                     kept_in     = '0;
                     largest_in  = '0;
                     found_in    = 1'b0;
                     state_in    = deaa_pkg::ST_SCAN;
                  end
                  default: begin
                     // mark, and unused codes behave as mark
                     res_addr_in = front_w[deaa_pkg::FIELD_W-1:0];
                  end
               endcase
            end
         end

         deaa_pkg::ST_SCAN: begin
            // issue the next read while compacting the entry that arrived
            if (scan_idx_ff < count_ff) begin
               ram_rd_en    = 1'b1;
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
               scan_pend_in = 1'b1;
            end
            if (scan_pend_ff) begin
               if (match_en_ff && (ram_rd_data == depth_ff)) begin
                  found_in = 1'b1;
               end else begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = kept_ff[ADDR_W-1:0];
                  ram_wr_data = ram_rd_data;
                  kept_in     = kept_ff + CNT_W'(1);
                  if (ram_rd_data > largest_ff) begin
                     largest_in = ram_rd_data;
                  end
               end
            end
            if (!(scan_idx_ff < count_ff) && !scan_pend_ff) begin
               count_in  = kept_ff;
               back_in   = largest_ff;
               status_in = found_ff ? deaa_pkg::STAT_OK : deaa_pkg::STAT_NOT_FOUND;
               state_in  = deaa_pkg::ST_DONE;
            end
         end

         deaa_pkg::ST_DONE: begin
            if (out_free) begin
               if (used_w[LEVEL_W-1:0] > peak_ff) begin
                  peak_in = used_w[LEVEL_W-1:0];
               end
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = status_ff;
               rsp_used_in   = used_w[deaa_pkg::FIELD_W-1:0];
               rsp_peak_in   = res_trunc(peak_in);
               state_in      = deaa_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = deaa_pkg::ST_IDLE;
         end
      endcase

      if (!buf_valid_ff) begin
         buf_valid_in = req_chan.valid;
      end else begin
         buf_valid_in = !req_take;
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deaa_pkg::ST_IDLE;
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         front_ff     <= '0;
         back_ff      <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         scan_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_valid_ff <= buf_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         front_ff     <= front_in;
         back_ff      <= back_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         scan_pend_ff <= scan_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         buf_opcode_ff  <= req_chan.opcode;
         buf_size_ff    <= req_chan.size;
         buf_address_ff <= req_chan.address;
      end
      res_addr_ff   <= res_addr_in;
      status_ff     <= status_in;
      scan_idx_ff   <= scan_idx_in;
      kept_ff       <= kept_in;
      largest_ff    <= largest_in;
      found_ff      <= found_in;
      depth_ff      <= depth_in;
      match_en_ff   <= match_en_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_peak_ff   <= rsp_peak_in;
   end

   // both regions together never exceed the arena
   `DEAA_ASSERT_NOW(a_no_overlap, clock, reset, 1'b1, used_w <= ARENA_WIDE)
   // peak never falls below current usage once a response has gone out
   `DEAA_ASSERT_NOW(a_peak_covers, clock, reset, state_ff == deaa_pkg::ST_IDLE,
                    used_w[LEVEL_W-1:0] <= peak_ff)
   // table fill stays within its depth
   `DEAA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= MAX_CNT)
   // compaction writes always land below the entry being read
   `DEAA_ASSERT_NOW(a_compact_order, clock, reset,
                    (state_ff == deaa_pkg::ST_SCAN) && ram_wr_en, kept_ff < scan_idx_ff)
   // a free never grows the table
   `DEAA_ASSERT_NEXT(a_free_shrinks, clock, reset, state_ff == deaa_pkg::ST_SCAN,
                     count_ff <= $past(count_ff))

endmodule

@@ src/deaa_ram.sv @@
// ---------------------------------------------------------------------------
// deaa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module deaa_ram #(
   parameter int WIDTH = 21,
   parameter int DEPTH = 128
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
